/* rtl/psu_pkg.sv */
// Shared types, constants and helper functions for the PNG scanline unfilter.
// Used by the front end, unfilter and output stages and the top; depends on nothing.
package psu_pkg;

  localparam int MAX_WIDTH_DEF       = 4096;
  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int IMG_W_W    = 13;
  localparam int MOD3_ARG_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_MODE  = 2'd0,
    REG_FOUR_BIT    = 2'd1,
    REG_IMAGE_WIDTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_PALETTE = 2'd0,
    MODE_RGB     = 2'd1,
    MODE_RGBA    = 2'd2
  } color_mode_t;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  typedef struct packed {
    logic        command;
    logic [7:0]  data_byte;
    logic        start_of_image;
    logic [7:0]  palette_index;
    logic [31:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_rgba;
    logic        row_end;
    logic        last;
  } out_item_t;

  // front end -> unfilter stage
  typedef struct packed {
    filter_t     filter;
    color_mode_t mode;
    logic        four_bit;
    logic        above_zero;
    logic        row_start;
    logic        row_end;
    logic        pixel_done;
    logic        two_pixels;
    logic [7:0]  data;
  } byte_ctl_t;

  // unfilter stage -> output stage
  typedef struct packed {
    logic        palette;
    logic        two_pixels;
    logic        row_end;
    logic [31:0] pixel;
    logic [7:0]  pal_addr0;
    logic [3:0]  pal_addr1;
  } pix_ctl_t;

  function automatic color_mode_t norm_mode(input logic [1:0] raw);
    color_mode_t m;
    unique case (raw)
      2'd0:    m = MODE_PALETTE;
      2'd1:    m = MODE_RGB;
      default: m = MODE_RGBA;
    endcase
    return m;
  endfunction

  // residue mod 3 by folding base-4 digits (4 = 1 mod 3)
  function automatic logic [1:0] mod3(input logic [MOD3_ARG_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < MOD3_ARG_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u = 3'(t[1:0]) + 3'(t[2]);
    return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
  endfunction

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [9:0] sum_ab;
    logic [9:0] two_c;
    logic [7:0] r;
    pa     = {2'b00, (b > c) ? (b - c) : (c - b)};
    pb     = {2'b00, (a > c) ? (a - c) : (c - a)};
    sum_ab = {2'b00, a} + {2'b00, b};
    two_c  = {1'b0, c, 1'b0};
    pc     = (sum_ab > two_c) ? (sum_ab - two_c) : (two_c - sum_ab);
    if (pa <= pb && pa <= pc) r = a;
    else if (pb <= pc)        r = b;
    else                      r = c;
    return r;
  endfunction

endpackage

/* rtl/psu_stream_if.sv */
// Valid/ready stream channel carrying one payload struct per beat.
// Payload types come from psu_pkg.
interface psu_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/psu_front.sv */
// Front end: configuration registers and row bookkeeping (position, filter type,
// first-row flag, line store fill count). Depends on psu_pkg.
module psu_front #(
  parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF,
  parameter int IDX_W     = $clog2(4 * MAX_WIDTH),
  parameter int POS_W     = $clog2(4 * MAX_WIDTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_en,
  input  logic [psu_pkg::CFG_IDX_W-1:0]   write_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  write_data,
  input  logic                            accept,
  input  psu_pkg::in_item_t               item,
  output logic                            load,
  output psu_pkg::byte_ctl_t              ctl,
  output logic [IDX_W-1:0]                idx
);

  localparam int W_W = $clog2(MAX_WIDTH + 1);

  logic [1:0]                  color_mode;
  logic                        four_bit_depth;
  logic [psu_pkg::IMG_W_W-1:0] image_width;
  logic [POS_W-1:0]            byte_position;
  psu_pkg::filter_t            row_filter;
  logic                        first_row;
  logic [POS_W-1:0]            fill_count;

  psu_pkg::color_mode_t mode;
  logic [W_W-1:0]       w;
  logic [POS_W-1:0]     rowlen;
  logic                 stale;
  logic [POS_W-1:0]     eff_pos;
  logic                 eff_first;
  logic                 is_filter;
  logic                 row_last;
  logic                 data_beat;

  always_comb begin
    mode = psu_pkg::norm_mode(color_mode);
    if (image_width == '0) begin
      w = W_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = W_W'(MAX_WIDTH);
    end else begin
      w = W_W'(image_width);
    end
    case (mode)
      psu_pkg::MODE_PALETTE: begin
        rowlen = four_bit_depth ? ((POS_W'(w) + POS_W'(1)) >> 1) : POS_W'(w);
      end
      psu_pkg::MODE_RGB: begin
        rowlen = (POS_W'(w) << 1) + POS_W'(w);
      end
      default: begin
        rowlen = POS_W'(w) << 2;
      end
    endcase
  end

  // a row left over from a wider configuration is closed silently
  assign stale     = byte_position > rowlen;
  assign eff_pos   = (item.start_of_image || stale) ? '0 : byte_position;
  assign eff_first = item.start_of_image || (first_row && !stale);
  assign is_filter = (eff_pos == '0);
  assign row_last  = (eff_pos == rowlen);
  assign idx       = IDX_W'(eff_pos - POS_W'(1));
  assign data_beat = accept && !item.command;
  assign load      = data_beat && !is_filter;

  always_comb begin
    ctl.filter     = row_filter;
    ctl.mode       = mode;
    ctl.four_bit   = four_bit_depth;
    ctl.above_zero = eff_first || (eff_pos > fill_count);
    ctl.row_start  = (eff_pos == POS_W'(1));
    ctl.row_end    = row_last;
    case (mode)
      psu_pkg::MODE_RGB:  ctl.pixel_done = (psu_pkg::mod3(psu_pkg::MOD3_ARG_W'(idx)) == 2'd2);
      psu_pkg::MODE_RGBA: ctl.pixel_done = (idx[1:0] == 2'b11);
      default:            ctl.pixel_done = 1'b1;
    endcase
    ctl.two_pixels = (POS_W+1)'({idx, 1'b1}) < (POS_W+1)'(w);
    ctl.data       = item.data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode     <= 2'd2;
      four_bit_depth <= 1'b0;
      image_width    <= psu_pkg::IMG_W_W'(1);
      byte_position  <= '0;
      row_filter     <= psu_pkg::FILT_NONE;
      first_row      <= 1'b1;
      fill_count     <= '0;
    end else begin
      if (write_en) begin
        unique case (write_index)
          psu_pkg::REG_COLOR_MODE:  color_mode     <= write_data[1:0];
          psu_pkg::REG_FOUR_BIT:    four_bit_depth <= write_data[0];
          psu_pkg::REG_IMAGE_WIDTH: image_width    <= write_data[psu_pkg::IMG_W_W-1:0];
          default: ;
        endcase
      end
      if (data_beat) begin
        if (is_filter) begin
          row_filter    <= (item.data_byte >= 8'd4) ? psu_pkg::FILT_PAETH
                                                    : psu_pkg::filter_t'(item.data_byte[2:0]);
          byte_position <= POS_W'(1);
          first_row     <= eff_first;
        end else begin
          byte_position <= row_last ? '0 : eff_pos + POS_W'(1);
          first_row     <= row_last ? 1'b0 : eff_first;
          if (eff_pos > fill_count) fill_count <= eff_pos;
        end
      end
    end
  end

endmodule

/* rtl/psu_unfilter.sv */
// Unfilter stage: line store (read when the byte is accepted), filter prediction and
// pixel assembly for RGB and RGBA, palette addresses otherwise. Depends on psu_pkg.
module psu_unfilter #(
  parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF,
  parameter int IDX_W     = $clog2(4 * MAX_WIDTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  psu_pkg::byte_ctl_t ctl_in,
  input  logic [IDX_W-1:0]   idx_in,
  input  logic               c_free,
  output logic               in_ready,
  output logic               c_load,
  output psu_pkg::pix_ctl_t  pix
);

  localparam int STORE_DEPTH = 4 * MAX_WIDTH;

  logic [7:0] store [STORE_DEPTH];
  logic [7:0] rd_q;

  logic               b_valid;
  psu_pkg::byte_ctl_t b_ctl;
  logic [IDX_W-1:0]   b_idx;
  logic [31:0]        left_bytes;
  logic [31:0]        upper_left_bytes;
  logic [23:0]        pixel_gather;

  logic        b_res;
  logic        b_go;
  logic [31:0] left_base;
  logic [31:0] upper_base;
  logic [23:0] gather_base;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  c;
  logic [8:0]  sum_ab;
  logic [7:0]  pred;
  logic [7:0]  x;

  assign b_res    = (b_ctl.mode == psu_pkg::MODE_PALETTE) || b_ctl.pixel_done;
  assign b_go     = b_valid && (!b_res || c_free);
  assign in_ready = !b_valid || b_go;
  assign c_load   = b_go && b_res;

  always_comb begin
    left_base   = b_ctl.row_start ? '0 : left_bytes;
    upper_base  = b_ctl.row_start ? '0 : upper_left_bytes;
    gather_base = b_ctl.row_start ? '0 : pixel_gather;
    case (b_ctl.mode)
      psu_pkg::MODE_PALETTE: begin
        a = left_base[7:0];
        c = upper_base[7:0];
      end
      psu_pkg::MODE_RGB: begin
        a = left_base[23:16];
        c = upper_base[23:16];
      end
      default: begin
        a = left_base[31:24];
        c = upper_base[31:24];
      end
    endcase
    b      = b_ctl.above_zero ? 8'h00 : rd_q;
    sum_ab = {1'b0, a} + {1'b0, b};
    case (b_ctl.filter)
      psu_pkg::FILT_SUB:   pred = a;
      psu_pkg::FILT_UP:    pred = b;
      psu_pkg::FILT_AVG:   pred = sum_ab[8:1];
      psu_pkg::FILT_PAETH: pred = psu_pkg::paeth(a, b, c);
      default:             pred = 8'h00;
    endcase
    x = b_ctl.data + pred;

    pix.palette    = (b_ctl.mode == psu_pkg::MODE_PALETTE);
    pix.two_pixels = pix.palette && b_ctl.four_bit && b_ctl.two_pixels;
    pix.row_end    = b_ctl.row_end;
    pix.pixel      = (b_ctl.mode == psu_pkg::MODE_RGB) ? {gather_base[15:0], x, 8'hFF}
                                                       : {gather_base, x};
    pix.pal_addr0  = b_ctl.four_bit ? {4'h0, x[7:4]} : x;
    pix.pal_addr1  = x[3:0];
  end

  // line store: read at accept, written when the byte leaves this stage
  always_ff @(posedge clk) begin
    if (load) rd_q <= store[idx_in];
    if (b_go) store[b_idx] <= x;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_ctl <= ctl_in;
      b_idx <= idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid          <= 1'b0;
      left_bytes       <= '0;
      upper_left_bytes <= '0;
      pixel_gather     <= '0;
    end else begin
      if (load)      b_valid <= 1'b1;
      else if (b_go) b_valid <= 1'b0;
      if (b_go) begin
        left_bytes       <= {left_base[23:0], x};
        upper_left_bytes <= {upper_base[23:0], b};
        if (b_ctl.mode != psu_pkg::MODE_PALETTE) begin
          pixel_gather <= b_ctl.pixel_done ? '0 : {gather_base[15:0], x};
        end
      end
    end
  end

endmodule

/* rtl/psu_format.sv */
// Output stage: palette table, result register and the two-pixel sequence
// of packed 4-bit indices. Depends on psu_pkg and psu_stream_if.
module psu_format #(
  parameter int PALETTE_ENTRIES = psu_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pal_we,
  input  logic [7:0]        pal_index,
  input  logic [31:0]       pal_color,
  input  logic              c_load,
  input  psu_pkg::pix_ctl_t pix_in,
  output logic              c_free,
  psu_stream_if.source      out
);

  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  logic [31:0] palette_table [PALETTE_ENTRIES];
  logic [31:0] rd0;
  logic [31:0] rd1;
  logic        oor0;

  logic        c_valid;
  logic        phase;
  logic        c_pal;
  logic        c_two;
  logic        c_re;
  logic [31:0] c_pix;
  logic        c_done;

  assign c_done = c_valid && out.ready && (!c_two || phase);
  assign c_free = !c_valid || c_done;

  always_ff @(posedge clk) begin
    if (pal_we && ({1'b0, pal_index} < 9'(PALETTE_ENTRIES))) begin
      palette_table[pal_index[PAL_AW-1:0]] <= pal_color;
    end
    if (c_load) begin
      rd0  <= palette_table[pix_in.pal_addr0[PAL_AW-1:0]];
      rd1  <= palette_table[PAL_AW'(pix_in.pal_addr1)];
      oor0 <= ({1'b0, pix_in.pal_addr0} >= 9'(PALETTE_ENTRIES));
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      c_pal <= pix_in.palette;
      c_two <= pix_in.two_pixels;
      c_re  <= pix_in.row_end;
      c_pix <= pix_in.pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      phase   <= 1'b0;
    end else if (c_load) begin
      c_valid <= 1'b1;
      phase   <= 1'b0;
    end else if (c_done) begin
      c_valid <= 1'b0;
    end else if (c_valid && out.ready && c_two) begin
      phase <= 1'b1;
    end
  end

  always_comb begin
    out.valid = c_valid;
    if (!c_pal)     out.data.pixel_rgba = c_pix;
    else if (phase) out.data.pixel_rgba = rd1;
    else            out.data.pixel_rgba = oor0 ? 32'h0 : rd0;
    out.data.row_end = c_re && (!c_two || phase);
    out.data.last    = !c_two || phase;
  end

endmodule

/* rtl/png_scanline_unfilter_core.sv */
// PNG scanline unfilter: takes one inflated byte per cycle on byte_in and
// gives RGBA pixels on pixel_out. A data byte is accepted every cycle as long
// as the output keeps up. The line store is read and the byte's stage register
// loads at acceptance; the unfilter adder then runs, and the result register
// and the palette read load when the byte leaves that stage, after which its
// pixel can be taken. With 4-bit palette indices a byte yields up to two
// pixels and the output register sends one pixel per cycle while pixel_out is
// ready, so input then slows to the output's pace. Filter bytes and palette
// writes (command 1) produce no pixel. The line store holds 4*MAX_WIDTH bytes;
// a fill count stands in for its reset, so there is no clearing pass after
// reset. Configuration is to be written by the user only while the block is
// idle; the block itself does not enforce this.
module png_scanline_unfilter_core #(
  parameter int MAX_WIDTH       = psu_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_ENTRIES = psu_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  psu_stream_if.sink                     byte_in,
  psu_stream_if.source                   pixel_out,
  input  logic                           write_en,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  write_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] write_data
);

  localparam int IDX_W = $clog2(4 * MAX_WIDTH);
  localparam int POS_W = $clog2(4 * MAX_WIDTH + 1);

  psu_pkg::in_item_t  item;
  logic               accept;
  logic               in_ready;
  logic               load;
  psu_pkg::byte_ctl_t ctl;
  logic [IDX_W-1:0]   idx;
  logic               c_free;
  logic               c_load;
  psu_pkg::pix_ctl_t  pix;

  assign item          = byte_in.data;
  assign byte_in.ready = in_ready;
  assign accept        = byte_in.valid && in_ready;

  psu_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .IDX_W     (IDX_W),
    .POS_W     (POS_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .accept      (accept),
    .item        (item),
    .load        (load),
    .ctl         (ctl),
    .idx         (idx)
  );

  psu_unfilter #(
    .MAX_WIDTH (MAX_WIDTH),
    .IDX_W     (IDX_W)
  ) u_unfilter (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .ctl_in   (ctl),
    .idx_in   (idx),
    .c_free   (c_free),
    .in_ready (in_ready),
    .c_load   (c_load),
    .pix      (pix)
  );

  psu_format #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_format (
    .clk       (clk),
    .rst       (rst),
    .pal_we    (accept && item.command),
    .pal_index (item.palette_index),
    .pal_color (item.palette_color),
    .c_load    (c_load),
    .pix_in    (pix),
    .c_free    (c_free),
    .out       (pixel_out)
  );

endmodule
